// ===== sv/rbff_pkg.sv =====
// Package for the run-based flood fill core: sizes, function codes and FSM states.
// No dependencies; used by run_based_flood_fill_core.
package rbff_pkg;
  localparam int IMAGE_WIDTH_DEF  = 256;
  localparam int IMAGE_HEIGHT_DEF = 256;
  localparam int PIXEL_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF  = 4096;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_FILL  = 2'd2;

  localparam logic [1:0] REG_TEST  = 2'd0;
  localparam logic [1:0] REG_SET   = 2'd1;
  localparam logic [1:0] REG_EIGHT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SEED_RD,
    S_SEED_CHK,
    S_GROW_R_RD,
    S_GROW_R_CHK,
    S_GROW_L_RD,
    S_GROW_L_CHK,
    S_PUSH,
    S_POP,
    S_POP_WAIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DONE,
    S_OUT
  } state_t;
endpackage

// ===== sv/run_based_flood_fill_core.sv =====
// Run-based flood fill core: image memory, run queue and fill sequencer.
// Depends on rbff_pkg.
//
// Usage. Input words arrive on s_axis: func 0 writes a pixel, func 1 reads
// one, func 2 starts a scanline fill from the seed (pos_x, pos_y). Every
// input word yields exactly one result word on m_axis carrying the read
// pixel, the bounding box of the last fill and the queue overflow flag.
// The configuration port sets test_value, set_value and eight_connected;
// the user must write it only while the core is idle; this is not enforced.
// Flow. One item is worked at a time, and s_axis_tready is low while it
// runs. Every pixel test is a registered read of the single-port image
// memory, which is the shared unit of the sequencer. A fill checks the
// seed, then per run grows it, queues it, takes it off the queue and scans
// the rows above and below; the neighbor span scanned is the run length,
// plus two with 8-connectivity.
// The result sits in an output register until m_axis_tready takes it; no
// new input is accepted until then.
// Reset sets the sequencer, held box and configuration registers to their
// reset values; image and queue contents stay undefined until written.
module run_based_flood_fill_core
  import rbff_pkg::*;
#(
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF,
  parameter int PIXEL_BITS   = PIXEL_BITS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[1:0], pos_x[9:2], pos_y[17:10], pixel_in[25:18], zero pad to 32
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_out[7:0], box_x_min[15:8], box_y_min[23:16], box_x_end[32:24],
  // box_y_end[41:33], queue_overflow[42], zero pad to 48
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam int XW = $clog2(IMAGE_WIDTH);
  localparam int YW = $clog2(IMAGE_HEIGHT);
  localparam int CW = (XW > YW ? XW : YW) + 2;   // signed coordinate width
  localparam int AW = XW + YW;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int SPW = 3 * CW;

  typedef logic signed [CW-1:0] coord_t;

  // Configuration.
  logic [7:0] test_value, set_value;
  logic       eight_connected;
  always_ff @(posedge clk) begin
    if (rst) begin
      test_value <= 8'd1;
      set_value <= 8'd2;
      eight_connected <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEST:  test_value <= cfg_data;
        REG_SET:   set_value <= cfg_data;
        REG_EIGHT: eight_connected <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [PIXEL_BITS-1:0] test_m, set_m;
  always_comb begin
    test_m = PIXEL_BITS'({24'd0, test_value});
    set_m  = PIXEL_BITS'({24'd0, set_value});
  end

  // Image memory, one port, registered read.
  logic [PIXEL_BITS-1:0] image_mem [2**AW];
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [PIXEL_BITS-1:0] mem_wdata, mem_rdata;
  always_ff @(posedge clk) begin
    if (mem_we) image_mem[mem_addr] <= mem_wdata;
    mem_rdata <= image_mem[mem_addr];
  end

  // Run queue memory.
  logic [SPW-1:0] queue_mem [2**QW];
  logic           q_we;
  logic [QW-1:0]  q_waddr;
  logic [SPW-1:0] q_wdata, q_rdata;
  logic [QW-1:0]  queue_head, queue_tail;
  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_waddr] <= q_wdata;
    q_rdata <= queue_mem[queue_head];
  end

  state_t state, state_next;

  // Item and sequencer registers.
  coord_t      seed_x, seed_y;
  coord_t      run_x0, run_x1, run_y;   // run being grown
  coord_t      span_x1, span_y;          // run taken off the queue
  coord_t      scan_x;
  logic        scan_lower;               // 0: row above, 1: row below
  logic        scan_active;              // a queued run is being scanned
  logic [QW:0]   queue_count;
  logic        overflowed;
  logic        probe_in;                 // probed pixel was inside the image
  coord_t      box_x0, box_y0, box_x1, box_y1;
  logic [7:0]  pixel_out;
  logic        ovf_out;

  function automatic logic inside_img(coord_t x, coord_t y);
    return x >= 0 && x < CW'(IMAGE_WIDTH) && y >= 0 && y < CW'(IMAGE_HEIGHT);
  endfunction

  function automatic logic [AW-1:0] addr_of(coord_t x, coord_t y);
    return {y[YW-1:0], x[XW-1:0]};
  endfunction

  logic   hit;   // registered read shows a matching pixel
  assign hit = probe_in && (mem_rdata == test_m);

  coord_t scan_row, scan_end;
  always_comb begin
    scan_row = scan_lower ? span_y + coord_t'(1) : span_y - coord_t'(1);
    scan_end = eight_connected ? span_x1 + coord_t'(1) : span_x1;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:
        if (s_axis_tvalid) begin
          if (s_axis_tdata[1:0] == FUNC_READ) state_next = S_RD_WAIT;
          else if (s_axis_tdata[1:0] == FUNC_FILL) state_next = S_SEED_RD;
          else state_next = S_OUT;
        end
      S_RD_WAIT:    state_next = S_OUT;
      S_SEED_RD:    state_next = S_SEED_CHK;
      S_SEED_CHK:
        if (test_m == set_m || !hit) state_next = S_DONE;
        else state_next = S_GROW_R_RD;
      S_GROW_R_RD:  state_next = S_GROW_R_CHK;
      S_GROW_R_CHK: state_next = hit ? S_GROW_R_RD : S_GROW_L_RD;
      S_GROW_L_RD:  state_next = S_GROW_L_CHK;
      S_GROW_L_CHK: state_next = hit ? S_GROW_L_RD : S_PUSH;
      // A run found while scanning returns to the scan of its parent run.
      S_PUSH:       state_next = scan_active ? S_SCAN_RD : S_POP;
      S_POP:        state_next = (queue_count == '0) ? S_DONE : S_POP_WAIT;
      S_POP_WAIT:   state_next = S_SCAN_RD;
      S_SCAN_RD:
        if (scan_x >= scan_end) state_next = S_POP;
        else state_next = S_SCAN_CHK;
      S_SCAN_CHK:
        if (hit) begin
          state_next = (queue_count >= (QW+1)'(QUEUE_DEPTH)) ? S_DONE : S_GROW_R_RD;
        end else state_next = S_SCAN_RD;
      S_DONE:       state_next = S_OUT;
      S_OUT:        state_next = m_axis_tready ? S_IDLE : S_OUT;
      default:      state_next = S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_we = 1'b0;
    mem_addr = addr_of(seed_x, seed_y);
    mem_wdata = set_m;
    q_we = 1'b0;
    q_waddr = queue_tail;
    q_wdata = {run_y, run_x1, run_x0};
    unique case (state)
      S_IDLE: begin
        mem_addr = addr_of(coord_t'(s_axis_tdata[9:2]), coord_t'(s_axis_tdata[17:10]));
        mem_wdata = PIXEL_BITS'({24'd0, s_axis_tdata[25:18]});
        mem_we = s_axis_tvalid && s_axis_tdata[1:0] == FUNC_WRITE &&
                 inside_img(coord_t'(s_axis_tdata[9:2]), coord_t'(s_axis_tdata[17:10]));
      end
      S_GROW_R_RD: mem_addr = addr_of(run_x1, run_y);
      S_GROW_R_CHK: begin
        mem_addr = addr_of(run_x1, run_y);
        mem_we = hit;
      end
      S_GROW_L_RD: mem_addr = addr_of(run_x0 - coord_t'(1), run_y);
      S_GROW_L_CHK: begin
        mem_addr = addr_of(run_x0 - coord_t'(1), run_y);
        mem_we = hit;
      end
      S_PUSH: q_we = 1'b1;
      S_SCAN_RD, S_SCAN_CHK: mem_addr = addr_of(scan_x, scan_row);
      default: ;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      box_x0 <= '0; box_y0 <= '0; box_x1 <= '0; box_y1 <= '0;
      queue_head <= '0; queue_tail <= '0; queue_count <= '0;
      overflowed <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE:
          if (s_axis_tvalid) begin
            seed_x <= coord_t'(s_axis_tdata[9:2]);
            seed_y <= coord_t'(s_axis_tdata[17:10]);
            probe_in <= inside_img(coord_t'(s_axis_tdata[9:2]),
                                   coord_t'(s_axis_tdata[17:10]));
            pixel_out <= '0;
            ovf_out <= 1'b0;
          end
        S_RD_WAIT:
          if (probe_in) pixel_out <= 8'({24'd0, mem_rdata});
        S_SEED_RD: begin
          box_x0 <= seed_x; box_y0 <= seed_y;
          box_x1 <= seed_x + coord_t'(1); box_y1 <= seed_y + coord_t'(1);
          overflowed <= 1'b0;
          scan_active <= 1'b0;
          queue_head <= '0; queue_tail <= '0; queue_count <= '0;
          run_x0 <= seed_x; run_x1 <= seed_x; run_y <= seed_y;
        end
        S_GROW_R_RD: probe_in <= inside_img(run_x1, run_y);
        S_GROW_R_CHK:
          if (hit) run_x1 <= run_x1 + coord_t'(1);
        S_GROW_L_RD: probe_in <= inside_img(run_x0 - coord_t'(1), run_y);
        S_GROW_L_CHK:
          if (hit) run_x0 <= run_x0 - coord_t'(1);
        S_PUSH: begin
          queue_tail <= queue_tail + QW'(1);
          queue_count <= queue_count + (QW+1)'(1);
          if (run_x0 < box_x0) box_x0 <= run_x0;
          if (run_y < box_y0) box_y0 <= run_y;
          if (run_x1 > box_x1) box_x1 <= run_x1;
          if (run_y + coord_t'(1) > box_y1) box_y1 <= run_y + coord_t'(1);
        end
        S_POP:
          if (queue_count != '0) begin
            queue_head <= queue_head + QW'(1);
            queue_count <= queue_count - (QW+1)'(1);
          end
        S_POP_WAIT: begin
          span_x1 <= coord_t'(q_rdata[2*CW-1:CW]);
          span_y  <= coord_t'(q_rdata[SPW-1:2*CW]);
          scan_x  <= eight_connected ? coord_t'(q_rdata[CW-1:0]) - coord_t'(1)
                                     : coord_t'(q_rdata[CW-1:0]);
          scan_lower <= 1'b0;
          scan_active <= 1'b1;
        end
        S_SCAN_RD: probe_in <= inside_img(scan_x, scan_row);
        S_SCAN_CHK: begin
          if (hit) begin
            if (queue_count >= (QW+1)'(QUEUE_DEPTH)) overflowed <= 1'b1;
            run_x0 <= scan_x; run_x1 <= scan_x; run_y <= scan_row;
          end
          // Each column is tested above, then below, before moving right.
          if (scan_lower) begin
            scan_lower <= 1'b0;
            scan_x <= scan_x + coord_t'(1);
          end else scan_lower <= 1'b1;
        end
        S_DONE: begin
          ovf_out <= overflowed;
          queue_head <= '0; queue_tail <= '0; queue_count <= '0;
        end
        default: ;
      endcase
    end
  end

  // Outputs.
  always_comb begin
    s_axis_tready = (state == S_IDLE);
    m_axis_tvalid = (state == S_OUT);
    m_axis_tdata = {5'd0, ovf_out, box_y1[8:0], box_x1[8:0],
                    box_y0[7:0], box_x0[7:0], pixel_out};
  end
endmodule

// ===== verif/rbff_checker.sv =====
// Scoreboard for the run-based flood fill core: watches the input, result and
// configuration channels, predicts every result word and compares it.
// Depends on rbff_pkg.
module rbff_checker
  import rbff_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IMG_W = IMAGE_WIDTH_DEF;
  localparam int IMG_H = IMAGE_HEIGHT_DEF;
  localparam int RUN_SLOTS = QUEUE_DEPTH_DEF;
  localparam int EXP_SLOTS = 16;

  typedef struct {
    logic [7:0] pixel;
    logic [7:0] x_min;
    logic [7:0] y_min;
    logic [8:0] x_end;
    logic [8:0] y_end;
    logic       ovf;
  } fill_result_t;

  typedef struct {
    int x0;
    int x1;
    int y;
  } run_t;

  logic [7:0]   pixels [0:IMG_W*IMG_H-1];
  run_t         run_buf [RUN_SLOTS];
  int           run_head, run_tail, run_cnt;
  fill_result_t expected_words [EXP_SLOTS];
  int           exp_wr, exp_rd;
  logic [7:0]   test_v, set_v;
  logic         eight_v;
  int           lo_x, lo_y, hi_x, hi_y;
  bit           ovf_seen;

  function automatic bit is_region(int x, int y);
    if (x < 0 || x >= IMG_W || y < 0 || y >= IMG_H) return 0;
    return pixels[y*IMG_W + x] === test_v;
  endfunction

  // Grows, recolors and queues the run at (x, y); a full queue sets overflow.
  function automatic bit grow_run(int x, int y);
    run_t r;
    if (run_cnt >= RUN_SLOTS) begin
      ovf_seen = 1;
      return 0;
    end
    r.x0 = x;
    r.x1 = x;
    r.y = y;
    while (is_region(r.x1, y)) begin
      pixels[y*IMG_W + r.x1] = set_v;
      r.x1++;
    end
    while (is_region(r.x0 - 1, y)) begin
      r.x0--;
      pixels[y*IMG_W + r.x0] = set_v;
    end
    run_buf[run_tail] = r;
    run_tail = (run_tail + 1) % RUN_SLOTS;
    run_cnt++;
    if (r.x0 < lo_x) lo_x = r.x0;
    if (r.y < lo_y) lo_y = r.y;
    if (r.x1 > hi_x) hi_x = r.x1;
    if (r.y + 1 > hi_y) hi_y = r.y + 1;
    return 1;
  endfunction

  function automatic void flood_from(int sx, int sy);
    run_t r;
    int   a, b;
    lo_x = sx;
    lo_y = sy;
    hi_x = sx + 1;
    hi_y = sy + 1;
    ovf_seen = 0;
    run_head = 0;
    run_tail = 0;
    run_cnt = 0;
    if (test_v == set_v || !is_region(sx, sy)) return;
    void'(grow_run(sx, sy));
    while (run_cnt > 0 && !ovf_seen) begin
      r = run_buf[run_head];
      run_head = (run_head + 1) % RUN_SLOTS;
      run_cnt--;
      a = eight_v ? r.x0 - 1 : r.x0;
      b = eight_v ? r.x1 + 1 : r.x1;
      for (int x = a; x < b && !ovf_seen; x++) begin
        if (is_region(x, r.y - 1) && !grow_run(x, r.y - 1)) break;
        if (is_region(x, r.y + 1) && !grow_run(x, r.y + 1)) break;
      end
    end
    run_head = 0;
    run_tail = 0;
    run_cnt = 0;
  endfunction

  task automatic report(string field, logic [8:0] got, logic [8:0] want);
    $display("%0t ns: result word field %s is %0d, predicted %0d", $time, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    fill_result_t e;
    logic [1:0]   func;
    logic [7:0]   px, py;
    if (rst) begin
      test_v = 8'd1;
      set_v = 8'd2;
      eight_v = 1'b0;
      lo_x = 0;
      lo_y = 0;
      hi_x = 0;
      hi_y = 0;
      exp_wr = 0;
      exp_rd = 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TEST:  test_v = cfg_data;
          REG_SET:   set_v = cfg_data;
          REG_EIGHT: eight_v = cfg_data[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        func = s_axis_tdata[1:0];
        px = s_axis_tdata[9:2];
        py = s_axis_tdata[17:10];
        e.pixel = 8'd0;
        e.ovf = 1'b0;
        case (func)
          FUNC_WRITE: pixels[py*IMG_W + px] = s_axis_tdata[25:18];
          FUNC_READ:  e.pixel = pixels[py*IMG_W + px];
          FUNC_FILL: begin
            flood_from(int'(px), int'(py));
            e.ovf = ovf_seen;
          end
          default: ;
        endcase
        e.x_min = lo_x[7:0];
        e.y_min = lo_y[7:0];
        e.x_end = hi_x[8:0];
        e.y_end = hi_y[8:0];
        expected_words[exp_wr % EXP_SLOTS] = e;
        exp_wr++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_wr == exp_rd) begin
          $display("%0t ns: result word arrived with nothing predicted", $time);
          fail_count++;
        end else begin
          e = expected_words[exp_rd % EXP_SLOTS];
          exp_rd++;
          if (m_axis_tdata[7:0] !== e.pixel)
            report("pixel_out", 9'(m_axis_tdata[7:0]), 9'(e.pixel));
          if (m_axis_tdata[15:8] !== e.x_min)
            report("box_x_min", 9'(m_axis_tdata[15:8]), 9'(e.x_min));
          if (m_axis_tdata[23:16] !== e.y_min)
            report("box_y_min", 9'(m_axis_tdata[23:16]), 9'(e.y_min));
          if (m_axis_tdata[32:24] !== e.x_end)
            report("box_x_end", m_axis_tdata[32:24], e.x_end);
          if (m_axis_tdata[41:33] !== e.y_end)
            report("box_y_end", m_axis_tdata[41:33], e.y_end);
          if (m_axis_tdata[42] !== e.ovf)
            report("queue_overflow", 9'(m_axis_tdata[42]), 9'(e.ovf));
        end
      end
    end
    pending <= exp_wr - exp_rd;
  end
endmodule

// ===== verif/tb_top.sv =====
// Top of the flood fill core testbench: clock, reset, stimulus and verdict.
// Depends on rbff_pkg, run_based_flood_fill_core and rbff_checker.
module tb_top;
  import rbff_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NOISE_SLOTS = 4096;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // func[1:0], pos_x[9:2], pos_y[17:10], pixel_in[25:18], zero pad to 32
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // pixel_out[7:0], box_x_min[15:8], box_y_min[23:16], box_x_end[32:24],
  // box_y_end[41:33], queue_overflow[42], zero pad to 48
  logic [47:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_TEST;
  logic [7:0]  cfg_data = '0;
  int          fail_count;
  int          pending;

  run_based_flood_fill_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rbff_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  // Result side: after each taken word the receiver stalls for a drawn number
  // of cycles. Now and then it runs a stretch without any stall.
  int sink_wait;
  int sink_free;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait <= 0;
      sink_free <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (sink_free > 0) begin
        sink_free <= sink_free - 1;
      end else if ($urandom_range(0, 19) == 0) begin
        sink_free <= 30;
      end else begin
        sink_wait = $urandom_range(0, 12);
        if (sink_wait != 0) m_axis_tready <= 1'b0;
      end
    end else if (!m_axis_tready) begin
      if (sink_wait <= 1) m_axis_tready <= 1'b1;
      sink_wait <= sink_wait - 1;
    end
  end

  // Generous limit: a clean run needs far less than this.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // The image is undefined until written, so stimulus only reads pixels it
  // has written, and fills only inside a window whose every pixel, plus a
  // one pixel ring of non-region value, was written first. A fill can then
  // neither leave the window nor read an unwritten pixel.
  logic [7:0] cur_test = 8'd1;
  int         words_sent;
  int         src_free;
  int         rx0, rx1, ry0, ry1;
  int         ix0, ix1, iy0, iy1;
  int         noise_addr [NOISE_SLOTS];
  int         noise_cnt = 0;

  // Offers one input word. tvalid stays high after a taken word; the next
  // call either keeps it high or lowers it for its gap.
  task automatic send_word(logic [1:0] func, int x, int y, logic [7:0] value);
    int gap;
    if (src_free > 0) begin
      src_free--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 19) == 0) src_free = 30;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, value, y[7:0], x[7:0], func};
    forever begin
      @(negedge clk);
      if (s_axis_tready) break;
    end
    @(posedge clk);
    words_sent++;
  endtask

  // Lowers tvalid and waits until every result word has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(logic [7:0] tv, logic [7:0] sv, logic eight);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_TEST;
    cfg_data <= tv;
    @(posedge clk);
    cfg_index <= REG_SET;
    cfg_data <= sv;
    @(posedge clk);
    cfg_index <= REG_EIGHT;
    cfg_data <= {7'd0, eight};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_test = tv;
  endtask

  // Noise: writes away from the live window, reads of written pixels, and
  // the unused function code.
  task automatic noise_word();
    int x, y;
    case ($urandom_range(0, 3))
      0: begin
        do begin
          x = $urandom_range(0, 255);
          y = $urandom_range(0, 255);
        end while (x >= rx0 && x <= rx1 && y >= ry0 && y <= ry1);
        if (noise_cnt < NOISE_SLOTS) begin
          noise_addr[noise_cnt] = y * 256 + x;
          noise_cnt++;
        end
        send_word(FUNC_WRITE, x, y, 8'($urandom_range(0, 255)));
      end
      1: begin
        if (noise_cnt != 0) begin
          x = noise_addr[$urandom_range(0, noise_cnt - 1)];
          send_word(FUNC_READ, x % 256, x / 256, 8'($urandom_range(0, 255)));
        end
      end
      2: send_word(2'd3, $urandom_range(0, 255), $urandom_range(0, 255),
                   8'($urandom_range(0, 255)));
      default: send_word(FUNC_READ, $urandom_range(rx0, rx1), $urandom_range(ry0, ry1),
                         8'($urandom_range(0, 255)));
    endcase
  endtask

  // Paints a window of mostly region pixels inside a non-region ring, then
  // runs several fills in it with reads, repaints and noise between them.
  task automatic fill_window(int wx, int wy, int ww, int wh, int fills);
    logic [7:0] ring_v;
    ix0 = wx;
    ix1 = wx + ww - 1;
    iy0 = wy;
    iy1 = wy + wh - 1;
    rx0 = (wx > 0) ? wx - 1 : 0;
    ry0 = (wy > 0) ? wy - 1 : 0;
    rx1 = (ix1 < 255) ? ix1 + 1 : 255;
    ry1 = (iy1 < 255) ? iy1 + 1 : 255;
    do ring_v = 8'($urandom_range(0, 255)); while (ring_v == cur_test);
    for (int y = ry0; y <= ry1; y++)
      for (int x = rx0; x <= rx1; x++) begin
        if (x >= ix0 && x <= ix1 && y >= iy0 && y <= iy1)
          send_word(FUNC_WRITE, x, y,
                    ($urandom_range(0, 3) != 0) ? cur_test : 8'($urandom_range(0, 255)));
        else
          send_word(FUNC_WRITE, x, y, ring_v);
      end
    for (int k = 0; k < fills; k++) begin
      // A seed drawn over the ring window may be a non-matching ring pixel.
      if ($urandom_range(0, 4) != 0)
        send_word(FUNC_FILL, $urandom_range(ix0, ix1), $urandom_range(iy0, iy1),
                  8'($urandom_range(0, 255)));
      else
        send_word(FUNC_FILL, $urandom_range(rx0, rx1), $urandom_range(ry0, ry1),
                  8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3))
        send_word(FUNC_READ, $urandom_range(rx0, rx1), $urandom_range(ry0, ry1),
                  8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 4))
        send_word(FUNC_WRITE, $urandom_range(ix0, ix1), $urandom_range(iy0, iy1), cur_test);
      repeat ($urandom_range(0, 2)) noise_word();
    end
  endtask

  initial begin
    int w, h;
    words_sent = 0;
    src_free = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, from reset register values on: the unused code before
    // any fill shows the all-zero box, then fills at corners and elsewhere.
    send_word(2'd3, 255, 255, 8'hFF);
    fill_window(0, 0, 5, 4, 2);
    fill_window(250, 251, 6, 5, 2);
    set_regs(8'd0, 8'd255, 1'b1);
    fill_window(0, 255, 256, 1, 1);
    fill_window(100, 3, 4, 4, 2);
    set_regs(8'd255, 8'd0, 1'b0);
    fill_window(251, 0, 5, 6, 2);
    // Test value equal to set value fills nothing.
    set_regs(8'd7, 8'd7, 1'b1);
    fill_window(40, 60, 3, 3, 1);

    // Random part: windows of random size and place under random settings;
    // every few windows the registers change.
    while (words_sent < 1700) begin
      if ($urandom_range(0, 3) == 0)
        set_regs(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0) ? cur_test :
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(13, 40);
        h = $urandom_range(1, 3);
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 12);
      end
      fill_window($urandom_range(0, 256 - w), $urandom_range(0, 256 - h), w, h,
                  $urandom_range(1, 4));
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
